### src/rgr_pkg.sv
// Shared types, widths and helpers for the rigid gradient reduction block.
// Used by rgr_cfg, rigid_gradient_reduction, rgr_checker and the testbench; depends on nothing else.
package rgr_pkg;

	// Largest frame the position counters must cover.
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	// Field widths fixed by the register map and the stream words.
	localparam int DIM_W  = 13;
	localparam int CTR_W  = 16;
	localparam int GRAD_W = 16;
	localparam int TX_W   = 40;
	localparam int ROT_W  = 57;

	// Column and row counters.
	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	// Signed Q.4 offset of a pixel from the center: position * 16 minus center.
	localparam int XPOS_W = ((COL_W + 4) > CTR_W) ? (COL_W + 4) : CTR_W;
	localparam int YPOS_W = ((ROW_W + 4) > CTR_W) ? (ROW_W + 4) : CTR_W;
	localparam int OFS_W  = ((XPOS_W > YPOS_W) ? XPOS_W : YPOS_W) + 1;

	// One product and the difference of two products.
	localparam int PROD_W = OFS_W + GRAD_W;
	localparam int TERM_W = PROD_W + 1;

	// APB register map.
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_CENTER_X     = 2'd2,
		REG_CENTER_Y     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0] frame_width;
		logic [DIM_W-1:0] frame_height;
		logic [CTR_W-1:0] center_x;
		logic [CTR_W-1:0] center_y;
	} cfg_t;

	// A zero dimension counts as one; anything above the maximum is cut to it.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
		logic [DIM_W-1:0] res;
		begin
			res = v;
			if (v == '0) begin
				res = DIM_W'(1);
			end else if (32'(v) > maxv) begin
				res = DIM_W'(maxv);
			end
			return res;
		end
	endfunction

endpackage

### src/rigid_gradient_reduction.sv
// Top level of the rigid gradient reduction block: stream input, three-stage
// datapath, output register. Depends on rgr_pkg and rgr_cfg.
//
// The block takes one gradient word (grad_x, grad_y) per clock in raster order
// and sums grad_x, grad_y and the rotational moment -(y-cy)*grad_x + (x-cx)*grad_y
// about the programmed center. After the last pixel of a frame it presents one
// result word holding the three sums and starts the next frame from zero. It
// sustains one input word per cycle while s_tready is high. A result word is
// offered once its last pixel has passed the pipeline: stage one registers the
// pixel with its offsets from the center, stage two registers the difference of
// the two products, and the third stage adds into the accumulators and loads the
// output register. Input words keep flowing while a result waits to be taken;
// s_tready drops only when a second frame result reaches the last stage before
// the first has been taken. Frame geometry and center must be written over APB
// only while the stream is idle; the block itself does not enforce this.
// Dimensions of zero count as one and larger ones are capped at 4096.
module rigid_gradient_reduction import rgr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// Input stream. tdata: grad_x [15:0], grad_y [31:16].
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,
	// Result stream. tdata: sum_tx [39:0], sum_ty [79:40], sum_rot [136:80], zeros above.
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [143:0]      m_tdata,
	// Configuration port.
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int CMPX_W = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
	localparam int CMPY_W = ((ROW_W > DIM_W) ? ROW_W : DIM_W) + 1;

	cfg_t cfg;

	rgr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// Raster position of the next pixel and end-of-row / end-of-frame decode.
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [DIM_W-1:0] width_eff;
	logic [DIM_W-1:0] height_eff;
	logic             row_end;
	logic             frame_end;
	logic             accept;

	assign width_eff  = clamp_dim(cfg.frame_width, MAX_WIDTH);
	assign height_eff = clamp_dim(cfg.frame_height, MAX_HEIGHT);
	assign row_end    = CMPX_W'(col_q) >= (CMPX_W'(width_eff) - CMPX_W'(1));
	assign frame_end  = row_end && (CMPY_W'(row_q) >= (CMPY_W'(height_eff) - CMPY_W'(1)));

	// Pipeline control. Only a frame result entering a full, stalled output
	// register holds the pipe.
	logic valid_s1, valid_s2;
	logic last_s1, last_s2;
	logic out_valid_q;
	logic load_out;
	logic stall;

	assign stall    = valid_s2 && last_s2 && out_valid_q && !m_tready;
	assign s_tready = !stall;
	assign accept   = s_tvalid && s_tready;
	assign load_out = valid_s2 && last_s2 && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				if (frame_end) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Stage one: register the gradients and the Q.4 offsets from the center.
	logic signed [GRAD_W-1:0] gx_s1, gy_s1;
	logic signed [OFS_W-1:0]  fx_s1, fy_s1;
	logic signed [OFS_W-1:0]  fx_d, fy_d;

	assign fx_d = signed'((OFS_W'(col_q) << 4) - OFS_W'(cfg.center_x));
	assign fy_d = signed'((OFS_W'(row_q) << 4) - OFS_W'(cfg.center_y));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			gx_s1   <= signed'(s_tdata[15:0]);
			gy_s1   <= signed'(s_tdata[31:16]);
			fx_s1   <= fx_d;
			fy_s1   <= fy_d;
			last_s1 <= frame_end;
		end
	end

	// Stage two: the two moment products and their difference.
	logic signed [PROD_W-1:0] prod_xy, prod_yx;
	logic signed [TERM_W-1:0] term_s2;
	logic signed [GRAD_W-1:0] gx_s2, gy_s2;

	assign prod_xy = fx_s1 * gy_s1;
	assign prod_yx = fy_s1 * gx_s1;

	always_ff @(posedge clk) begin
		if (!stall) begin
			term_s2 <= TERM_W'(prod_xy) - TERM_W'(prod_yx);
			gx_s2   <= gx_s1;
			gy_s2   <= gy_s1;
			last_s2 <= last_s1;
		end
	end

	// Stage three: accumulate; on the frame's last pixel the updated sums go
	// to the output register and the accumulators restart from zero.
	logic [TX_W-1:0]  acc_tx_q, acc_ty_q, out_tx_q, out_ty_q;
	logic [ROT_W-1:0] acc_rot_q, out_rot_q;
	logic [TX_W-1:0]  sum_tx_d, sum_ty_d;
	logic [ROT_W-1:0] sum_rot_d;

	assign sum_tx_d  = acc_tx_q + TX_W'(gx_s2);
	assign sum_ty_d  = acc_ty_q + TX_W'(gy_s2);
	assign sum_rot_d = acc_rot_q + ROT_W'(term_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_tx_q  <= '0;
			acc_ty_q  <= '0;
			acc_rot_q <= '0;
		end else if (valid_s2 && !stall) begin
			if (last_s2) begin
				acc_tx_q  <= '0;
				acc_ty_q  <= '0;
				acc_rot_q <= '0;
			end else begin
				acc_tx_q  <= sum_tx_d;
				acc_ty_q  <= sum_ty_d;
				acc_rot_q <= sum_rot_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_tx_q  <= sum_tx_d;
			out_ty_q  <= sum_ty_d;
			out_rot_q <= sum_rot_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_rot_q, out_ty_q, out_tx_q};

endmodule

### src/rgr_cfg.sv
// APB register file of the rigid gradient reduction block.
// Depends on rgr_pkg for the register map and the configuration struct.
module rgr_cfg import rgr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	// Registers sit on word addresses; the byte offset bits are ignored.
	assign idx   = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= DIM_W'(1);
			cfg_q.frame_height <= DIM_W'(1);
			cfg_q.center_x     <= '0;
			cfg_q.center_y     <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[DIM_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[DIM_W-1:0];
				REG_CENTER_X:     cfg_q.center_x     <= pwdata[CTR_W-1:0];
				REG_CENTER_Y:     cfg_q.center_y     <= pwdata[CTR_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_FRAME_WIDTH:  prdata = DATA_W'(cfg_q.frame_width);
			REG_FRAME_HEIGHT: prdata = DATA_W'(cfg_q.frame_height);
			REG_CENTER_X:     prdata = DATA_W'(cfg_q.center_x);
			REG_CENTER_Y:     prdata = DATA_W'(cfg_q.center_y);
			default:          prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### src/rgr_checker.sv
// Port-level checks for the rigid gradient reduction block, bound to the top level.
// Depends on rgr_pkg for the configuration port widths.
module rgr_checker import rgr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [143:0]      m_tdata,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	input logic [DATA_W-1:0] prdata,
	input logic              pready
);

	// A result word that is not taken stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word dropped or changed while stalled");

	// The input side can only back up behind a pending result word.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with no result pending");

	// The low DIM_W bits of a register read back what was written to it in the previous cycle.
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready ##1 psel && !pwrite && paddr == $past(paddr)
		|-> prdata[DIM_W-1:0] == $past(pwdata[DIM_W-1:0]))
		else $error("register readback mismatch");

	// No register is wider than its center field; the rest reads zero.
	a_read_upper: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[DATA_W-1:CTR_W] == '0)
		else $error("nonzero upper read data");

endmodule

bind rigid_gradient_reduction rgr_checker u_rgr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata),
	.pready   (pready)
);

### test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for rigid_gradient_reduction: streams gradient frames,
// predicts the three frame sums and compares each result word field by field.
// Depends on rgr_pkg and the block's RTL only.
module tb;
	import rgr_pkg::*;

	// Generous cycle budget for about a thousand pixels with random gaps on both
	// sides and a few hundred register accesses.
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PIXELS = 800;
	localparam int IDLE_PCT = 25;

	// One frame result: the sum of grad_x, the sum of grad_y and the moment sum.
	typedef struct {
		logic [TX_W-1:0]  tx;
		logic [TX_W-1:0]  ty;
		logic [ROT_W-1:0] rot;
	} frame_sums_t;

	// Tracks the block's position and running sums from the accepted pixels and
	// keeps the frame results that are still owed by the block.
	class frame_sum_tracker;
		logic [DIM_W-1:0] width_reg, height_reg;
		logic [CTR_W-1:0] cx_reg, cy_reg;
		int col, row;
		logic [TX_W-1:0]  run_tx, run_ty;
		logic [ROT_W-1:0] run_rot;
		frame_sums_t owed_sums[$];
		int mismatches, pixels, frames_seen, reg_writes;

		function new();
			width_reg = 1;
			height_reg = 1;
			cx_reg = '0;
			cy_reg = '0;
			col = 0;
			row = 0;
			run_tx = '0;
			run_ty = '0;
			run_rot = '0;
			mismatches = 0;
			pixels = 0;
			frames_seen = 0;
			reg_writes = 0;
		endfunction

		function int eff_dim(logic [DIM_W-1:0] v, int maxv);
			if (v == '0) begin
				return 1;
			end
			if (int'(v) > maxv) begin
				return maxv;
			end
			return int'(v);
		endfunction

		function int frame_pixels();
			return eff_dim(width_reg, MAX_WIDTH) * eff_dim(height_reg, MAX_HEIGHT);
		endfunction

		function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_FRAME_WIDTH: begin
					width_reg = val[DIM_W-1:0];
				end
				REG_FRAME_HEIGHT: begin
					height_reg = val[DIM_W-1:0];
				end
				REG_CENTER_X: begin
					cx_reg = val[CTR_W-1:0];
				end
				default: begin
					cy_reg = val[CTR_W-1:0];
				end
			endcase
			reg_writes++;
		endfunction

		function logic [DATA_W-1:0] reg_value(reg_idx_t idx);
			case (idx)
				REG_FRAME_WIDTH:  return DATA_W'(width_reg);
				REG_FRAME_HEIGHT: return DATA_W'(height_reg);
				REG_CENTER_X:     return DATA_W'(cx_reg);
				default:          return DATA_W'(cy_reg);
			endcase
		endfunction

		function int owed_count();
			return owed_sums.size();
		endfunction

		// Adds one pixel to the running sums and, at the end of a frame, queues
		// the finished sums and starts over.
		function void take_pixel(logic signed [GRAD_W-1:0] gx, logic signed [GRAD_W-1:0] gy);
			int w, h;
			longint gxl, gyl, fx, fy, moment;
			frame_sums_t done;
			w = eff_dim(width_reg, MAX_WIDTH);
			h = eff_dim(height_reg, MAX_HEIGHT);
			gxl = longint'(gx);
			gyl = longint'(gy);
			fx = longint'(col) * 16 - longint'(cx_reg);
			fy = longint'(row) * 16 - longint'(cy_reg);
			moment = fx * gyl - fy * gxl;
			run_tx = run_tx + gxl[TX_W-1:0];
			run_ty = run_ty + gyl[TX_W-1:0];
			run_rot = run_rot + moment[ROT_W-1:0];
			pixels++;
			if (col >= w - 1) begin
				col = 0;
				if (row >= h - 1) begin
					done.tx = run_tx;
					done.ty = run_ty;
					done.rot = run_rot;
					owed_sums.push_back(done);
					row = 0;
					run_tx = '0;
					run_ty = '0;
					run_rot = '0;
				end else begin
					row++;
				end
			end else begin
				col++;
			end
		endfunction

		task flag_mismatch(string what, logic [63:0] want, logic [63:0] seen);
			mismatches++;
			if (mismatches <= 40) begin
				$display("%0t MISMATCH %s: wanted %h, saw %h", $time, what, want, seen);
			end
		endtask

		task match_result(logic [143:0] word);
			frame_sums_t got, want;
			got.tx = word[39:0];
			got.ty = word[79:40];
			got.rot = word[136:80];
			frames_seen++;
			if (owed_sums.size() == 0) begin
				flag_mismatch("result word with no frame pending", '0, 64'(got.tx));
				return;
			end
			want = owed_sums.pop_front();
			if (got.tx !== want.tx) begin
				flag_mismatch("sum_tx", 64'(want.tx), 64'(got.tx));
			end
			if (got.ty !== want.ty) begin
				flag_mismatch("sum_ty", 64'(want.ty), 64'(got.ty));
			end
			if (got.rot !== want.rot) begin
				flag_mismatch("sum_rot", 64'(want.rot), 64'(got.rot));
			end
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [31:0]       s_tdata;    // grad_x [15:0], grad_y [31:16]
	logic              m_tvalid;
	logic              m_tready;
	logic [143:0]      m_tdata;    // sum_tx [39:0], sum_ty [79:40], sum_rot [136:80]
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	frame_sum_tracker sb = new();

	// While this is set neither side inserts idle cycles, so the block also
	// sees a long stretch of back-to-back words.
	bit steady = 1'b0;
	int random_sent = 0;
	int cycles = 0;

	rigid_gradient_reduction dut (.*);

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// The watchdog counts clock cycles and ends a run that hangs.
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("rigid_gradient_reduction verification failed");
		$finish;
	end

	// The result side is ready at random about three quarters of the time, and always while steady is set.
	// m_tready changes only at the falling edge, so it is stable at the
	// rising edge where the handshake is sampled.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Every word taken on the result side is compared against the oldest
	// frame result still owed.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.match_result(m_tdata);
		end
	end

	// Picks a gradient component, biased toward the extremes of Q8.8.
	function automatic logic [GRAD_W-1:0] pick_grad();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return $urandom_range(1) ? 16'hffff : 16'h0001;
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Writes one register with a setup and an access cycle, then reads it back.
	// Called at a falling edge; returns at a falling edge with the bus idle.
	task automatic program_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(idx));
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== sb.reg_value(idx)) begin
			sb.flag_mismatch("register read-back", 64'(sb.reg_value(idx)), 64'(prdata));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Offers one pixel word, with random idle cycles ahead of it, and notes it
	// once the block has taken it. s_tvalid stays high into the next word so
	// back-to-back words need no second assignment in one time step.
	task automatic send_pixel(logic [GRAD_W-1:0] gx, logic [GRAD_W-1:0] gy);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {gy, gx};
		do @(posedge clk); while (!s_tready);
		sb.take_pixel(gx, gy);
		@(negedge clk);
	endtask

	// Holds the input until every owed result has come back, then lets the
	// three-stage pipeline empty of pixels that end no frame. Only after this
	// is the block idle enough for a register write.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.owed_count() != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	// One random phase: a new geometry and center (some registers left as they
	// are), then a few whole frames of random pixels. Now and then the phase
	// stops inside a frame, so the next phase changes geometry mid-frame.
	task automatic random_phase();
		int w, h, frames, n;
		w = $urandom_range(99);
		w = (w < 5) ? 0 : (w < 75) ? $urandom_range(1, 6) : $urandom_range(7, 20);
		h = $urandom_range(99);
		h = (h < 5) ? 0 : (h < 80) ? $urandom_range(1, 5) : $urandom_range(6, 12);
		settle();
		if ($urandom_range(9) < 8) begin
			program_reg(REG_FRAME_WIDTH, DATA_W'(w));
		end
		if ($urandom_range(9) < 8) begin
			program_reg(REG_FRAME_HEIGHT, DATA_W'(h));
		end
		if ($urandom_range(9) < 6) begin
			program_reg(REG_CENTER_X, $urandom_range(3) == 0 ? 32'hffff : 32'($urandom_range(65535)));
		end
		if ($urandom_range(9) < 6) begin
			program_reg(REG_CENTER_Y, $urandom_range(3) == 0 ? 32'h0 : 32'($urandom_range(65535)));
		end
		frames = $urandom_range(1, 3);
		n = frames * sb.frame_pixels();
		if ($urandom_range(4) == 0) begin
			n = n + $urandom_range(1, sb.frame_pixels());
		end
		steady = (random_sent >= 300) && (random_sent < 450);
		repeat (n) begin
			send_pixel(pick_grad(), pick_grad());
			random_sent++;
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset geometry is one pixel per frame, so every word is a frame.
		send_pixel(16'h7fff, 16'h8000);
		send_pixel(16'h8000, 16'h7fff);
		send_pixel(16'h0000, 16'h0000);
		send_pixel(16'hffff, 16'h0001);

		// A 3x2 frame of extreme gradients about a center at the far x corner.
		settle();
		program_reg(REG_FRAME_WIDTH, 32'd3);
		program_reg(REG_FRAME_HEIGHT, 32'd2);
		program_reg(REG_CENTER_X, 32'hffff);
		program_reg(REG_CENTER_Y, 32'h0);
		send_pixel(16'h8000, 16'h8000);
		send_pixel(16'h7fff, 16'h7fff);
		send_pixel(16'h8000, 16'h7fff);
		send_pixel(16'h7fff, 16'h8000);
		send_pixel(16'hffff, 16'hffff);
		send_pixel(16'h0001, 16'h0000);

		// A 2x2 frame with the center moved to the far y corner.
		settle();
		program_reg(REG_FRAME_WIDTH, 32'd2);
		program_reg(REG_CENTER_X, 32'h0);
		program_reg(REG_CENTER_Y, 32'hffff);
		send_pixel(16'h8000, 16'h7fff);
		send_pixel(16'h7fff, 16'h8000);
		send_pixel(16'h8000, 16'h8000);
		send_pixel(16'h7fff, 16'h7fff);

		// Zero width and height count as one pixel per frame.
		settle();
		program_reg(REG_FRAME_WIDTH, 32'd0);
		program_reg(REG_FRAME_HEIGHT, 32'd0);
		send_pixel(16'h1234, 16'hedcb);
		send_pixel(16'h8000, 16'h0001);

		// An oversized width is capped to 4096-pixel rows, then the width shrinks
		// in the middle of the first row: the column is already past the new last
		// column, so the next pixel ends the row.
		settle();
		program_reg(REG_FRAME_WIDTH, 32'd8191);
		program_reg(REG_FRAME_HEIGHT, 32'd2);
		repeat (3) send_pixel(pick_grad(), pick_grad());
		settle();
		program_reg(REG_FRAME_WIDTH, 32'd2);
		repeat (3) send_pixel(pick_grad(), pick_grad());

		// An oversized height cut short: with the height dropped to one, the
		// next row end closes the frame although two rows have passed.
		settle();
		program_reg(REG_FRAME_WIDTH, 32'd1);
		program_reg(REG_FRAME_HEIGHT, 32'd5000);
		repeat (2) send_pixel(pick_grad(), pick_grad());
		settle();
		program_reg(REG_FRAME_HEIGHT, 32'd1);
		send_pixel(pick_grad(), pick_grad());

		// Random phases, mostly whole frames of small geometry.
		while (random_sent < RANDOM_PIXELS) begin
			random_phase();
		end

		// Wait for the last result word, then keep the clock running so that any
		// stray word from the block would still be caught.
		settle();
		repeat (20) @(negedge clk);
		if (sb.owed_count() != 0) begin
			sb.flag_mismatch("frame results never delivered", 64'(sb.owed_count()), '0);
		end

		$display("Covered %0d pixels and %0d frame results over %0d register writes,",
			sb.pixels, sb.frames_seen, sb.reg_writes);
		$display("from one-pixel frames to oversized geometry changed in mid-frame.");
		if (sb.mismatches == 0) begin
			$display("rigid_gradient_reduction verification clean");
		end else begin
			$display("rigid_gradient_reduction verification failed");
		end
		$finish;
	end
endmodule

### rigid_gradient_reduction.f
src/rgr_pkg.sv
src/rgr_cfg.sv
src/rigid_gradient_reduction.sv
src/rgr_checker.sv
test/tb.sv
